>>> rtl/tpd_pkg.sv
// Shared types and constants for the template pattern distance block.
// No dependencies; every other file in rtl/ imports this package.
package tpd_pkg;

  localparam int DIST_W      = 56;
  localparam int TERM_W      = 54;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [DIST_W-1:0] DIST_MAX  = '1;
  localparam logic [29:0]       FAR_SCALE = 30'd1000000000;

  // Measure modes
  localparam logic [1:0] MODE_MISMATCH = 2'd1;
  localparam logic [1:0] MODE_SQDIFF   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_GRID_X = 2'd0;
  localparam logic [1:0] CFG_GRID_Y = 2'd1;
  localparam logic [1:0] CFG_GRID_Z = 2'd2;
  localparam logic [1:0] CFG_MODE   = 2'd3;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_ADD,
    ACT_SET
  } act_e;

  typedef enum logic {
    BK_RUN,
    BK_DIV
  } back_state_e;

  typedef struct packed {
    logic [10:0] size_x;
    logic [10:0] size_y;
    logic [10:0] size_z;
    logic [1:0]  mode;
  } cfg_t;

  // One classified request, passed from the front to the back
  typedef struct packed {
    logic              query;
    logic              last;
    logic [1:0]        mode;
    act_e              act;
    logic [TERM_W-1:0] term;
  } op_t;

endpackage

>>> rtl/tpd_front.sv
// Front end: accepts requests, runs the grid test and builds the distance term.
// Depends on tpd_pkg.
module tpd_front #(
  parameter int GRID_MAX = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tpd_pkg::cfg_t       cfg_i,
  input  logic                push_i,
  output logic                full_o,
  input  logic                kind_i,
  input  logic [9:0]          center_x_i,
  input  logic [9:0]          center_y_i,
  input  logic [9:0]          center_z_i,
  input  logic signed [9:0]   offset_x_i,
  input  logic signed [9:0]   offset_y_i,
  input  logic signed [9:0]   offset_z_i,
  input  logic [7:0]          cond_value_i,
  input  logic [7:0]          image_value_i,
  input  logic [15:0]         weight_i,
  input  logic                last_i,
  output logic                op_valid_o,
  output tpd_pkg::op_t        op_o,
  input  logic                op_ready_i
);
  import tpd_pkg::*;

  localparam logic [16:0] GRID_LIM = 17'(GRID_MAX);

  function automatic logic coord_in(input logic [9:0] c, input logic [9:0] o,
                                    input logic [10:0] ext);
    logic signed [11:0] pos;
    logic [16:0]        lim;
    pos = $signed({2'b00, c}) + $signed({{2{o[9]}}, o});
    lim = (17'(ext) > GRID_LIM) ? GRID_LIM : 17'(ext);
    return !pos[11] && (17'(pos[10:0]) < lim);
  endfunction

  // Stage 1: classification
  logic        s1_valid_q, s1_valid_d;
  logic        s1_query_q, s1_last_q, s1_inside_q, s1_neq_q;
  logic [1:0]  s1_mode_q;
  logic [15:0] s1_dsq_q, dsq;
  logic [15:0] s1_w_q;
  logic [7:0]  diff;
  logic        in_grid;

  // Stage 2: finished request
  logic        s2_valid_q, s2_valid_d;
  op_t         op_q, op_d;

  logic        stall, s2_en, accept;
  logic [29:0] mul_a;
  logic [45:0] prod;

  assign stall  = s2_valid_q && !op_ready_i;
  assign s2_en  = !stall;
  assign full_o = s1_valid_q && stall;
  assign accept = push_i && !full_o;

  assign in_grid = coord_in(center_x_i, offset_x_i, cfg_i.size_x) &&
                   coord_in(center_y_i, offset_y_i, cfg_i.size_y) &&
                   coord_in(center_z_i, offset_z_i, cfg_i.size_z);
  assign diff   = (image_value_i > cond_value_i) ? image_value_i - cond_value_i
                                                 : cond_value_i - image_value_i;
  assign dsq    = {8'd0, diff} * {8'd0, diff};

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (!s1_valid_q || s2_en) begin
      s1_valid_d = accept;
    end
    s2_valid_d = s2_en ? s1_valid_q : s2_valid_q;
  end

  // Term: one multiply, squared difference or far penalty against the weight
  assign mul_a = s1_inside_q ? {14'd0, s1_dsq_q} : FAR_SCALE;
  assign prod  = mul_a * {14'd0, s1_w_q};

  always_comb begin
    op_d.query = s1_query_q;
    op_d.last  = s1_last_q;
    op_d.mode  = s1_mode_q;
    op_d.act   = ACT_NONE;
    op_d.term  = '0;
    case (s1_mode_q)
      MODE_MISMATCH: begin
        op_d.term = TERM_W'({s1_w_q, 8'd0});
        if (!s1_inside_q || s1_neq_q) begin
          op_d.act = ACT_ADD;
        end
      end
      MODE_SQDIFF: begin
        if (s1_inside_q) begin
          op_d.act  = ACT_ADD;
          op_d.term = TERM_W'(prod[45:8]);
        end else begin
          op_d.act  = ACT_SET;
          op_d.term = {prod, 8'd0};
        end
      end
      default: begin
        op_d.act = ACT_NONE;
      end
    endcase
    if (s1_query_q) begin
      op_d.act = ACT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_query_q  <= kind_i;
      s1_last_q   <= last_i;
      s1_mode_q   <= cfg_i.mode;
      s1_inside_q <= in_grid;
      s1_neq_q    <= image_value_i != cond_value_i;
      s1_dsq_q    <= dsq;
      s1_w_q      <= weight_i;
    end
    if (s2_en && s1_valid_q) begin
      op_q <= op_d;
    end
  end

  assign op_valid_o = s2_valid_q;
  assign op_o       = op_q;

endmodule

>>> rtl/tpd_fifo.sv
// Short request queue between the front and the back.
// Depends on tpd_pkg.
module tpd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tpd_pkg::op_t  data_i,
  output logic          full_o,
  input  logic          pop_i,
  output tpd_pkg::op_t  data_o,
  output logic          empty_o
);
  import tpd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/tpd_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tpd_pkg.
module tpd_div #(
  parameter int DVS_W = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tpd_pkg::DIST_W-1:0] dividend_i,
  input  logic [DVS_W-1:0]           divisor_i,
  output logic                       busy_o,
  output logic [tpd_pkg::DIST_W-1:0] quotient_o
);
  import tpd_pkg::*;

  localparam int STEP_W = $clog2(DIST_W);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [DIST_W-1:0] quo_q;
  logic [DVS_W-1:0]  rem_q, dvs_q;
  logic [DVS_W:0]    shifted;
  logic              ge;

  assign shifted = {rem_q, quo_q[DIST_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == STEP_W'(DIST_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIST_W-2:0], ge};
      rem_q <= ge ? DVS_W'(shifted - {1'b0, dvs_q}) : shifted[DVS_W-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/tpd_back.sv
// Back end: sums weighted distances, emits one per template end or query.
// Depends on tpd_pkg and tpd_div.
module tpd_back #(
  parameter int MAX_NEIGHBOURS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tpd_pkg::op_t               op_i,
  input  logic                       op_empty_i,
  output logic                       op_pop_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [tpd_pkg::DIST_W-1:0] distance_o
);
  import tpd_pkg::*;

  localparam int              CNT_W   = $clog2(MAX_NEIGHBOURS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NEIGHBOURS);

  back_state_e       state_q, state_d;
  logic [DIST_W-1:0] sum_q, sum_d, sum_acc, res_val, out_dist_q, quotient;
  logic [DIST_W:0]   add_sum;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_acc;
  logic              out_valid_q;
  logic              take, ends, use_div, slot_free, res_wr, div_start, div_busy;

  assign take      = cnt_q < MAX_CNT;
  assign add_sum   = {1'b0, sum_q} + (DIST_W + 1)'(op_i.term);
  assign cnt_acc   = take ? cnt_q + 1'b1 : cnt_q;
  assign ends      = op_i.query || op_i.last;
  assign use_div   = !op_i.query && (op_i.mode == MODE_SQDIFF) && (cnt_acc != '0);
  assign slot_free = !out_valid_q || pop_i;

  always_comb begin
    sum_acc = sum_q;
    if (take) begin
      case (op_i.act)
        ACT_ADD: sum_acc = add_sum[DIST_W] ? DIST_MAX : add_sum[DIST_W-1:0];
        ACT_SET: sum_acc = DIST_W'(op_i.term);
        default: sum_acc = sum_q;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_RUN: begin
        if (!op_empty_i && ends && use_div) begin
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (!div_busy && slot_free) begin
          state_d = BK_RUN;
        end
      end
      default: state_d = BK_RUN;
    endcase
  end

  // Outputs
  always_comb begin
    op_pop_o  = 1'b0;
    div_start = 1'b0;
    res_wr    = 1'b0;
    res_val   = '0;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    case (state_q)
      BK_RUN: begin
        if (!op_empty_i) begin
          if (!ends) begin
            op_pop_o = 1'b1;
            sum_d    = sum_acc;
            cnt_d    = cnt_acc;
          end else if (use_div) begin
            op_pop_o  = 1'b1;
            div_start = 1'b1;
            sum_d     = '0;
            cnt_d     = '0;
          end else if (slot_free) begin
            op_pop_o = 1'b1;
            res_wr   = 1'b1;
            if (!op_i.query && op_i.mode == MODE_MISMATCH) begin
              res_val = sum_acc;
            end
            sum_d = '0;
            cnt_d = '0;
          end
        end
      end
      BK_DIV: begin
        if (!div_busy && slot_free) begin
          res_wr  = 1'b1;
          res_val = quotient;
        end
      end
      default: begin
        op_pop_o = 1'b0;
      end
    endcase
  end

  tpd_div #(
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_acc),
    .divisor_i  (cnt_acc),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_RUN;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      if (res_wr) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_wr) begin
      out_dist_q <= res_val;
    end
  end

  assign empty_o    = !out_valid_q;
  assign distance_o = out_dist_q;

endmodule

>>> rtl/template_pattern_distance.sv
// Top level of the weighted template pattern distance block.
// Depends on tpd_pkg, tpd_front, tpd_fifo and tpd_back.
//
// Usage
//   Requests enter through a queue-style port: a request is taken at a rising
//   edge with push high and full low. Each request is one template neighbour
//   (kind 0) or an empty-template query (kind 1). Mark the final neighbour
//   with last; the distance then appears on distance_o while empty is low and
//   leaves on an edge with pop high and empty low.
//   Write the grid extents and the measure mode through cfg_we_i, cfg_idx_i
//   and cfg_wdata_i only while the block is idle.
// Timing
//   The front classifies a request in two register stages, a four-entry
//   queue decouples it from the back, and the back accumulates one request
//   per clock unless it waits at a template end for a divide or for the
//   result slot. A mode-2 template end holds the back while the bit-serial
//   divider forms the mean, one quotient bit per cycle over 56 bits, and
//   until the result slot is free; the front keeps taking requests until
//   its stages and the queue fill.
// Reset and stalls
//   Reset empties every stage, clears the running sum and count and loads the
//   register defaults. A held result stalls the back at the next template end
//   or query, which fills the queue and then raises full; nothing is dropped.
module template_pattern_distance #(
  parameter int MAX_NEIGHBOURS = 64,
  parameter int GRID_MAX       = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [10:0]                cfg_wdata_i,
  input  logic                       push,
  output logic                       full,
  input  logic                       kind_i,
  input  logic [9:0]                 center_x_i,
  input  logic [9:0]                 center_y_i,
  input  logic [9:0]                 center_z_i,
  input  logic signed [9:0]          offset_x_i,
  input  logic signed [9:0]          offset_y_i,
  input  logic signed [9:0]          offset_z_i,
  input  logic [7:0]                 cond_value_i,
  input  logic [7:0]                 image_value_i,
  input  logic [15:0]                weight_i,
  input  logic                       last_i,
  input  logic                       pop,
  output logic                       empty,
  output logic [tpd_pkg::DIST_W-1:0] distance_o
);
  import tpd_pkg::*;

  cfg_t cfg_q;
  op_t  front_op, queue_op;
  logic front_valid, queue_full, queue_empty, queue_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_x <= 11'd1024;
      cfg_q.size_y <= 11'd1024;
      cfg_q.size_z <= 11'd1;
      cfg_q.mode   <= MODE_MISMATCH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_X: cfg_q.size_x <= cfg_wdata_i;
        CFG_GRID_Y: cfg_q.size_y <= cfg_wdata_i;
        CFG_GRID_Z: cfg_q.size_z <= cfg_wdata_i;
        CFG_MODE:   cfg_q.mode   <= cfg_wdata_i[1:0];
        default:    cfg_q.mode   <= cfg_q.mode;
      endcase
    end
  end

  // Front: grid test and term per neighbour
  tpd_front #(
    .GRID_MAX (GRID_MAX)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .push_i        (push),
    .full_o        (full),
    .kind_i        (kind_i),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .center_z_i    (center_z_i),
    .offset_x_i    (offset_x_i),
    .offset_y_i    (offset_y_i),
    .offset_z_i    (offset_z_i),
    .cond_value_i  (cond_value_i),
    .image_value_i (image_value_i),
    .weight_i      (weight_i),
    .last_i        (last_i),
    .op_valid_o    (front_valid),
    .op_o          (front_op),
    .op_ready_i    (!queue_full)
  );

  // Decoupling queue
  tpd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_op),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .data_o  (queue_op),
    .empty_o (queue_empty)
  );

  // Back: accumulate, divide, hold the result
  tpd_back #(
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (queue_op),
    .op_empty_i (queue_empty),
    .op_pop_o   (queue_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .distance_o (distance_o)
  );

endmodule

>>> rtl/tpd_checker.sv
// Port-level checks for template_pattern_distance, attached by bind.
// Depends on tpd_pkg.
module tpd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       push,
  input logic                       full,
  input logic                       pop,
  input logic                       empty,
  input logic [tpd_pkg::DIST_W-1:0] distance_o
);
  import tpd_pkg::*;

  // Reset leaves no result waiting and the input open
  a_reset_clear: assert property (@(posedge clk_i)
    !rst_ni |=> empty && !full)
    else $error("result or full flag active after a reset edge");

  // A waiting result holds until it is taken
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(distance_o))
    else $error("waiting result changed or vanished");

  // Back-pressure only builds when a new request has just been taken
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full raised without a new request");

endmodule

bind template_pattern_distance tpd_checker u_tpd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .pop        (pop),
  .empty      (empty),
  .distance_o (distance_o)
);

>>> tb/sv/tb.sv
// Self-checking testbench for template_pattern_distance: queue-style requests
// in, distances out, checked against a scoreboard that predicts each template.
// Depends on tpd_pkg and the template_pattern_distance RTL.
module tb;
  import tpd_pkg::*;

  localparam int MAX_NEIGHBOURS = 64;
  localparam int GRID_MAX       = 1024;
  localparam int SETTLE_CYCLES  = 80;    // covers the divide plus the pipe
  localparam int QUIET_LIMIT    = 2000;  // cycles with no handshake before giving up
  localparam int REPORT_LIMIT   = 10;

  localparam logic KIND_NEIGHBOUR = 1'b0;
  localparam logic KIND_QUERY     = 1'b1;

  // Modes other than mismatch and squared difference both give zero
  localparam logic [1:0] MODE_ZERO_LO = 2'd0;
  localparam logic [1:0] MODE_ZERO_HI = 2'd3;

  localparam logic [63:0] FAR_UNITS = 64'(FAR_SCALE) << 8;
  localparam logic [63:0] SUM_CEIL  = 64'(DIST_MAX);

  typedef struct packed {
    logic        kind;
    logic [9:0]  cx;
    logic [9:0]  cy;
    logic [9:0]  cz;
    logic [9:0]  ox;
    logic [9:0]  oy;
    logic [9:0]  oz;
    logic [7:0]  cond;
    logic [7:0]  img;
    logic [15:0] weight;
    logic        last;
  } request_t;

  // Scoreboard: mirrors the accumulator and register file, and keeps the
  // distances still owed by the block in arrival order.
  class distance_board;
    logic [10:0]       ext_x;
    logic [10:0]       ext_y;
    logic [10:0]       ext_z;
    logic [1:0]        mode;
    logic [63:0]       sum;
    logic [7:0]        count;
    logic [DIST_W-1:0] expected_distances[$];
    int                errors;
    int                checked;
    int                requests;
    int                beyond_limit;
    int                far_sets;

    function new();
      ext_x = 11'd1024;
      ext_y = 11'd1024;
      ext_z = 11'd1;
      mode  = MODE_MISMATCH;
      sum   = '0;
      count = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [10:0] val);
      case (idx)
        CFG_GRID_X: ext_x = val;
        CFG_GRID_Y: ext_y = val;
        CFG_GRID_Z: ext_z = val;
        CFG_MODE:   mode  = val[1:0];
        default: ;
      endcase
    endfunction

    // Queue one distance at the back of the owed list
    function void owe(logic [DIST_W-1:0] d);
      expected_distances.insert(expected_distances.size(), d);
    endfunction

    function bit axis_inside(logic [9:0] c, logic [9:0] o, logic [10:0] ext);
      int pos;
      int lim;
      pos = int'(c) + int'($signed(o));
      lim = (ext > GRID_MAX) ? GRID_MAX : int'(ext);
      return pos >= 0 && pos < lim;
    endfunction

    function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > SUM_CEIL) ? SUM_CEIL : s;
    endfunction

    function void note_request(request_t r);
      bit          in_grid;
      logic [63:0] diff;
      logic [63:0] term;
      logic [63:0] result;
      requests++;
      // An empty-template query answers zero and drops any partial template
      if (r.kind == KIND_QUERY) begin
        sum   = '0;
        count = '0;
        owe('0);
        return;
      end
      if (count < MAX_NEIGHBOURS) begin
        in_grid = axis_inside(r.cx, r.ox, ext_x) && axis_inside(r.cy, r.oy, ext_y) &&
                  axis_inside(r.cz, r.oz, ext_z);
        if (mode == MODE_MISMATCH) begin
          if (!in_grid || r.img != r.cond) sum = sat_add(sum, {40'd0, r.weight, 8'd0});
        end else if (mode == MODE_SQDIFF) begin
          if (in_grid) begin
            diff = (r.img > r.cond) ? 64'(r.img) - 64'(r.cond) : 64'(r.cond) - 64'(r.img);
            sum  = sat_add(sum, (diff * diff * 64'(r.weight)) >> 8);
          end else begin
            // An outside neighbour replaces the running sum outright
            term = FAR_UNITS * 64'(r.weight);
            sum  = (term > SUM_CEIL) ? SUM_CEIL : term;
            far_sets++;
          end
        end
        count = count + 8'd1;
      end else begin
        beyond_limit++;
      end
      if (!r.last) return;
      if (mode == MODE_MISMATCH) result = sum;
      else if (mode == MODE_SQDIFF && count != 0) result = sum / 64'(count);
      else result = '0;
      owe(result[DIST_W-1:0]);
      sum   = '0;
      count = '0;
    endfunction

    function void check_distance(logic [DIST_W-1:0] got);
      logic [DIST_W-1:0] want;
      if (expected_distances.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) $display("unexpected distance %0d with none owed", got);
        return;
      end
      want = expected_distances.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("distance %0d wrong: expected %0d, got %0d", checked, want, got);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = '0;
  logic [10:0]       cfg_wdata_i = '0;
  logic              push = 1'b0;
  logic              full;
  logic              kind_i = 1'b0;
  logic [9:0]        center_x_i = '0;
  logic [9:0]        center_y_i = '0;
  logic [9:0]        center_z_i = '0;
  logic [9:0]        offset_x_i = '0;
  logic [9:0]        offset_y_i = '0;
  logic [9:0]        offset_z_i = '0;
  logic [7:0]        cond_value_i = '0;
  logic [7:0]        image_value_i = '0;
  logic [15:0]       weight_i = '0;
  logic              last_i = 1'b0;
  logic              pop = 1'b0;
  logic              empty;
  logic [DIST_W-1:0] distance_o;

  bit            steady = 1'b0;  // set: neither side idles
  int            quiet_cycles = 0;
  int            settings_run = 0;
  distance_board board = new();

  template_pattern_distance #(
    .MAX_NEIGHBOURS(MAX_NEIGHBOURS),
    .GRID_MAX      (GRID_MAX)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .center_z_i   (center_z_i),
    .offset_x_i   (offset_x_i),
    .offset_y_i   (offset_y_i),
    .offset_z_i   (offset_z_i),
    .cond_value_i (cond_value_i),
    .image_value_i(image_value_i),
    .weight_i     (weight_i),
    .last_i       (last_i),
    .pop          (pop),
    .empty        (empty),
    .distance_o   (distance_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result side: check every popped distance, randomise pop, and run the
  // watchdog on cycles in which neither handshake completes.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) board.check_distance(distance_o);
      pop <= steady || ($urandom_range(99) >= 26);
      if ((pop && !empty) || (push && !full)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles < QUIET_LIMIT) begin
        quiet_cycles <= quiet_cycles + 1;
      end else begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("template_pattern_distance: mismatch");
        $finish;
      end
    end
  end

  function automatic request_t make_req(input logic kind, input int cx, cy, cz, ox, oy, oz,
                                        input int cond, img, w, input logic last);
    request_t r;
    r.kind   = kind;
    r.cx     = 10'(cx);
    r.cy     = 10'(cy);
    r.cz     = 10'(cz);
    r.ox     = 10'(ox);
    r.oy     = 10'(oy);
    r.oz     = 10'(oz);
    r.cond   = 8'(cond);
    r.img    = 8'(img);
    r.weight = 16'(w);
    r.last   = last;
    return r;
  endfunction

  // Pick a centre and offset along one axis: mostly near the grid edges or
  // close to the centre, now and then fully random bits.
  function automatic void pick_axis(input logic [10:0] ext, output logic [9:0] c,
                                    output logic [9:0] o);
    int lim;
    int pos;
    lim = (ext > GRID_MAX) ? GRID_MAX : int'(ext);
    if (lim == 0 || $urandom_range(99) < 15) begin
      c = 10'($urandom);
      o = 10'($urandom);
    end else begin
      case ($urandom_range(3))
        0:       c = 10'd0;
        1:       c = 10'(lim - 1);
        default: c = 10'($urandom_range(lim - 1));
      endcase
      if ($urandom_range(3) == 0) pos = int'($urandom_range(lim - 1));
      else pos = int'(c) + int'($urandom_range(4)) - 2;
      if (pos - int'(c) > 511 || pos - int'(c) < -512) pos = int'(c);
      o = 10'(pos - int'(c));
    end
  endfunction

  function automatic request_t random_neighbour(input logic last);
    request_t r;
    int       roll;
    r.kind = KIND_NEIGHBOUR;
    pick_axis(board.ext_x, r.cx, r.ox);
    pick_axis(board.ext_y, r.cy, r.oy);
    pick_axis(board.ext_z, r.cz, r.oz);
    r.cond = 8'($urandom);
    r.img  = ($urandom_range(1) == 1) ? r.cond : 8'($urandom);
    roll   = $urandom_range(99);
    r.weight = (roll < 10) ? 16'h0000 : (roll < 20) ? 16'hFFFF : 16'($urandom);
    r.last = last;
    return r;
  endfunction

  // Present one request and hold it until it is taken; idle beforehand at random.
  task automatic send_request(input request_t r);
    while (!steady && $urandom_range(99) < 26) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    kind_i        <= r.kind;
    center_x_i    <= r.cx;
    center_y_i    <= r.cy;
    center_z_i    <= r.cz;
    offset_x_i    <= r.ox;
    offset_y_i    <= r.oy;
    offset_z_i    <= r.oz;
    cond_value_i  <= r.cond;
    image_value_i <= r.img;
    weight_i      <= r.weight;
    last_i        <= r.last;
    @(posedge clk_i);
    while (full !== 1'b0) @(posedge clk_i);
    board.note_request(r);
  endtask

  // Hold off the sender until every owed distance is back, then let any
  // divide or partial template in flight drain before the registers change.
  task automatic settle();
    push <= 1'b0;
    while (board.expected_distances.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [10:0] sx, sy, sz, input logic [1:0] m);
    logic [1:0]  idx[4];
    logic [10:0] val[4];
    idx = '{CFG_GRID_X, CFG_GRID_Y, CFG_GRID_Z, CFG_MODE};
    // Junk in the upper data bits of the mode write must be dropped
    val = '{sx, sy, sz, {9'($urandom), m}};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
      board.set_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  // Mostly well-formed templates of random length (a few beyond the neighbour
  // limit), mixed with stray queries and stray neighbours. A phase may stop
  // mid-template, so the next setting lands inside it.
  task automatic run_random(input int n);
    int       sent;
    int       len;
    int       roll;
    request_t r;
    sent = 0;
    while (sent < n) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        r = random_neighbour(1'($urandom));
        r.kind = KIND_QUERY;
        send_request(r);
        sent++;
      end else if (roll < 12) begin
        send_request(random_neighbour(1'($urandom)));
        sent++;
      end else begin
        roll = $urandom_range(99);
        if (roll < 85) len = $urandom_range(8, 1);
        else if (roll < 95) len = $urandom_range(40, 9);
        else len = $urandom_range(72, 60);
        for (int i = 0; i < len && sent < n; i++) begin
          send_request(random_neighbour(i == len - 1));
          sent++;
        end
      end
    end
  endtask

  task automatic run_phase(input logic [10:0] sx, sy, sz, input logic [1:0] m,
                           input bit no_idle);
    settle();
    write_regs(sx, sy, sz, m);
    steady = no_idle;
    run_random(180);
    steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults: mismatch mode on a 1024 x 1024 x 1 grid.
    // Query with every other field set: answers zero.
    send_request(make_req(KIND_QUERY, 1023, 1023, 1023, -1, -1, -1, 255, 255, 65535, 1'b1));
    send_request(make_req(KIND_NEIGHBOUR, 0, 0, 0, 0, 0, 0, 255, 255, 65535, 1'b1));
    send_request(make_req(KIND_NEIGHBOUR, 1023, 1023, 0, 0, 0, 0, 0, 255, 65535, 1'b1));
    // Outside below and above on x, above on y and z, then a corner just inside
    send_request(make_req(KIND_NEIGHBOUR, 0, 0, 0, -512, 0, 0, 5, 5, 256, 1'b0));
    send_request(make_req(KIND_NEIGHBOUR, 1023, 0, 0, 511, 0, 0, 5, 5, 256, 1'b0));
    send_request(make_req(KIND_NEIGHBOUR, 0, 1023, 0, 0, 511, 0, 7, 7, 1, 1'b0));
    send_request(make_req(KIND_NEIGHBOUR, 0, 0, 0, 0, 0, 1, 7, 7, 1, 1'b0));
    send_request(make_req(KIND_NEIGHBOUR, 512, 512, 0, -512, 511, 0, 3, 3, 2, 1'b1));
    // A partial template wiped out by a query
    send_request(make_req(KIND_NEIGHBOUR, 100, 100, 0, 1, 1, 0, 1, 2, 300, 1'b0));
    send_request(make_req(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    // Leave a mismatch open so the mode change falls inside this template
    send_request(make_req(KIND_NEIGHBOUR, 9, 9, 0, 0, 0, 0, 1, 200, 256, 1'b0));

    settle();
    write_regs(11'd1024, 11'd1024, 11'd1024, MODE_SQDIFF);
    send_request(make_req(KIND_NEIGHBOUR, 0, 0, 1023, 0, 0, 0, 0, 255, 65535, 1'b0));
    send_request(make_req(KIND_NEIGHBOUR, 4, 4, 4, 0, 0, 0, 9, 9, 1, 1'b1));
    // Far neighbour overwrites the sum, later inside terms add on top
    send_request(make_req(KIND_NEIGHBOUR, 5, 5, 1023, 0, 0, 1, 0, 0, 65535, 1'b0));
    send_request(make_req(KIND_NEIGHBOUR, 5, 5, 5, 0, 0, 0, 10, 11, 256, 1'b1));
    send_request(make_req(KIND_NEIGHBOUR, 6, 6, 6, -1, -1, -1, 255, 0, 65535, 1'b0));
    send_request(make_req(KIND_NEIGHBOUR, 0, 6, 6, -1, 0, 0, 1, 1, 3, 1'b0));
    send_request(make_req(KIND_NEIGHBOUR, 6, 6, 6, 1, 1, 1, 0, 128, 200, 1'b1));
    send_request(make_req(KIND_QUERY, 1, 2, 3, 4, 5, 6, 7, 8, 9, 1'b1));

    // Zero-extent grid and the two modes that always answer zero
    settle();
    write_regs(11'd0, 11'd1024, 11'd1, MODE_ZERO_LO);
    send_request(make_req(KIND_NEIGHBOUR, 0, 0, 0, 0, 0, 0, 0, 255, 65535, 1'b1));
    settle();
    write_regs(11'd0, 11'd1024, 11'd1, MODE_ZERO_HI);
    send_request(make_req(KIND_NEIGHBOUR, 0, 0, 0, 0, 0, 0, 0, 255, 65535, 1'b1));
    settle();
    write_regs(11'd0, 11'd1024, 11'd1, MODE_MISMATCH);
    send_request(make_req(KIND_NEIGHBOUR, 0, 0, 0, 0, 0, 0, 3, 3, 1000, 1'b1));

    // Random phases across a spread of grids and modes, extremes included;
    // one phase runs with both sides flat out.
    run_phase(11'd1024, 11'd1024, 11'd1,    MODE_MISMATCH, 1'b0);
    run_phase(11'd2047, 11'd2047, 11'd2047, MODE_SQDIFF,   1'b0);
    run_phase(11'd1,    11'd1,    11'd1,    MODE_MISMATCH, 1'b0);
    run_phase(11'd0,    11'd7,    11'd3,    MODE_SQDIFF,   1'b0);
    run_phase(11'd33,   11'd17,   11'd9,    MODE_MISMATCH, 1'b1);
    run_phase(11'd64,   11'd64,   11'd64,   MODE_SQDIFF,   1'b0);
    run_phase(11'd1024, 11'd1024, 11'd1024, MODE_ZERO_HI,  1'b0);
    run_phase(11'd300,  11'd1,    11'd700,  MODE_ZERO_LO,  1'b0);
    run_phase(11'($urandom_range(2047, 1)), 11'($urandom_range(2047, 1)),
              11'($urandom_range(2047, 1)), MODE_SQDIFF, 1'b0);
    settle();

    $display("%0d requests over %0d register settings, %0d distances checked",
             board.requests, settings_run, board.checked);
    $display("%0d neighbours beyond the template limit, %0d far-neighbour overwrites",
             board.beyond_limit, board.far_sets);
    if (board.errors == 0) begin
      $display("template_pattern_distance: match");
    end else begin
      $display("template_pattern_distance: mismatch");
    end
    $finish;
  end

endmodule
